// File: sv/assert_macros.svh
// Assertion macros shared by the evaluator RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define CRSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CRSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CRSE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CRSE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: sv/crse_pkg.sv
// Shared constants and codes for the Catmull-Rom spline evaluator.
// No dependencies; used by the top-level evaluator module.
package crse_pkg;

    localparam int IDX_WIDTH   = 8;
    localparam int U_WIDTH     = 24;
    localparam int CNT_WIDTH   = 9;
    localparam int ST_WIDTH    = 2;
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;
    localparam int PIPE_STAGES = 9;
    localparam int MIN_POINTS  = 4;

    localparam int MAX_POINTS_DEF  = 256;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic REG_POINT_COUNT = 1'b0;

    localparam logic [ST_WIDTH-1:0] ST_OK    = 2'd0;
    localparam logic [ST_WIDTH-1:0] ST_FEW   = 2'd1;
    localparam logic [ST_WIDTH-1:0] ST_CLAMP = 2'd2;

endpackage

// File: sv/crse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crse_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// File: sv/crse_axis.sv
// Pipelined Horner evaluation of one coordinate: position, velocity, acceleration.
// Depends on nothing but its parameters; stage enables come from the top level.
module crse_axis #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          clk,
    input  logic [9:2]                    en,
    input  logic signed [COORD_WIDTH-1:0] p0,
    input  logic signed [COORD_WIDTH-1:0] p1,
    input  logic signed [COORD_WIDTH-1:0] p2,
    input  logic signed [COORD_WIDTH-1:0] p3,
    input  logic [FRAC_BITS:0]            t_in,
    output logic signed [COORD_WIDTH-1:0] pos,
    output logic signed [COORD_WIDTH-1:0] vel,
    output logic signed [COORD_WIDTH-1:0] acc
);

    localparam int W  = COORD_WIDTH;
    localparam int HW = COORD_WIDTH + 8;
    localparam int PW = HW + FRAC_BITS + 2;
    localparam int TW = FRAC_BITS + 1;

    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [HW-1:0] SAT_HI = {{(HW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [HW-1:0] SAT_LO = ~SAT_HI;

    // Rounded scaling of a product by one unit of t.
    function automatic logic signed [HW-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p + HALF;
        rnd = HW'(s >>> FRAC_BITS);
    endfunction

    // Halve with rounding, then saturate to the coordinate range.
    function automatic logic signed [W-1:0] finish(input logic signed [HW-1:0] h);
        logic signed [HW-1:0] s;
        s = (h + HW'(1)) >>> 1;
        if (s > SAT_HI)
        begin
            s = SAT_HI;
        end
        else if (s < SAT_LO)
        begin
            s = SAT_LO;
        end
        finish = W'(s);
    endfunction

    logic signed [HW-1:0] e0, e1, e2, e3;
    logic signed [HW-1:0] c3x3;
    logic signed [TW:0]   ts2, ts4, ts6;

    logic signed [HW-1:0] c0_2_reg, c1_2_reg, c2_2_reg, c3_2_reg;
    logic [TW-1:0]        t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
    logic signed [PW-1:0] pa_3_reg, pv_3_reg, pc_3_reg;
    logic signed [HW-1:0] c0_3_reg, c1_3_reg, c2_3_reg;
    logic signed [HW-1:0] ha_4_reg, hv_4_reg, hc_4_reg, c0_4_reg, c1_4_reg;
    logic signed [PW-1:0] pa_5_reg, pv_5_reg;
    logic signed [HW-1:0] c0_5_reg, c1_5_reg;
    logic signed [W-1:0]  acc_5_reg, acc_6_reg, acc_7_reg, acc_8_reg;
    logic signed [HW-1:0] ha_6_reg, hv_6_reg, c0_6_reg, c0_7_reg;
    logic signed [PW-1:0] pa_7_reg;
    logic signed [W-1:0]  vel_7_reg, vel_8_reg;
    logic signed [HW-1:0] h_8_reg;
    logic signed [W-1:0]  pos_9_reg, vel_9_reg, acc_9_reg;

    assign e0   = HW'(p0);
    assign e1   = HW'(p1);
    assign e2   = HW'(p2);
    assign e3   = HW'(p3);
    assign c3x3 = (c3_2_reg <<< 1) + c3_2_reg;
    assign ts2  = $signed({1'b0, t2_reg});
    assign ts4  = $signed({1'b0, t4_reg});
    assign ts6  = $signed({1'b0, t6_reg});

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c0_2_reg <= e1 <<< 1;
            c1_2_reg <= e2 - e0;
            c2_2_reg <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
            c3_2_reg <= (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3 - e0;
            t2_reg   <= t_in;
        end
        if (en[3])
        begin
            pa_3_reg <= c3_2_reg * ts2;
            pv_3_reg <= c3x3 * ts2;
            pc_3_reg <= (c3x3 <<< 1) * ts2;
            c0_3_reg <= c0_2_reg;
            c1_3_reg <= c1_2_reg;
            c2_3_reg <= c2_2_reg;
            t3_reg   <= t2_reg;
        end
        if (en[4])
        begin
            ha_4_reg <= c2_3_reg + rnd(pa_3_reg);
            hv_4_reg <= (c2_3_reg <<< 1) + rnd(pv_3_reg);
            hc_4_reg <= (c2_3_reg <<< 1) + rnd(pc_3_reg);
            c0_4_reg <= c0_3_reg;
            c1_4_reg <= c1_3_reg;
            t4_reg   <= t3_reg;
        end
        if (en[5])
        begin
            pa_5_reg  <= ha_4_reg * ts4;
            pv_5_reg  <= hv_4_reg * ts4;
            acc_5_reg <= finish(hc_4_reg);
            c0_5_reg  <= c0_4_reg;
            c1_5_reg  <= c1_4_reg;
            t5_reg    <= t4_reg;
        end
        if (en[6])
        begin
            ha_6_reg  <= c1_5_reg + rnd(pa_5_reg);
            hv_6_reg  <= c1_5_reg + rnd(pv_5_reg);
            acc_6_reg <= acc_5_reg;
            c0_6_reg  <= c0_5_reg;
            t6_reg    <= t5_reg;
        end
        if (en[7])
        begin
            pa_7_reg  <= ha_6_reg * ts6;
            vel_7_reg <= finish(hv_6_reg);
            acc_7_reg <= acc_6_reg;
            c0_7_reg  <= c0_6_reg;
        end
        if (en[8])
        begin
            h_8_reg   <= c0_7_reg + rnd(pa_7_reg);
            vel_8_reg <= vel_7_reg;
            acc_8_reg <= acc_7_reg;
        end
        if (en[9])
        begin
            pos_9_reg <= finish(h_8_reg);
            vel_9_reg <= vel_8_reg;
            acc_9_reg <= acc_8_reg;
        end
    end

    assign pos = pos_9_reg;
    assign vel = vel_9_reg;
    assign acc = acc_9_reg;

endmodule

// File: sv/catmull_rom_spline_evaluator_unit.sv
// Uniform Catmull-Rom spline evaluator: point table, segment selection and two axis pipelines.
// Depends on crse_pkg, crse_ram, crse_axis and assert_macros.svh.
// Pipeline: each accepted evaluate transaction passes, in order, through
// the table read stage and the eight arithmetic stages, the last of which is the output register.
// One transaction per cycle unless out_ready stalls; a stage stalls only if the next is full.
// Reset: rst_n, asynchronous and active low, clears the valid bits and point_count only.

`include "assert_macros.svh"

module catmull_rom_spline_evaluator_unit #(
    parameter int MAX_POINTS  = crse_pkg::MAX_POINTS_DEF,
    parameter int COORD_WIDTH = crse_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = crse_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [crse_pkg::PADDR_WIDTH-1:0]      paddr,
    input  logic [crse_pkg::PDATA_WIDTH-1:0]      pwdata,
    output logic [crse_pkg::PDATA_WIDTH-1:0]      prdata,
    output logic                                  pready,
    // Input channel.
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  opcode,
    input  logic [crse_pkg::IDX_WIDTH-1:0]        point_index,
    input  logic signed [COORD_WIDTH-1:0]         point_x,
    input  logic signed [COORD_WIDTH-1:0]         point_y,
    input  logic [crse_pkg::U_WIDTH-1:0]          param_u,
    // Output channel.
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [COORD_WIDTH-1:0]         pos_x,
    output logic signed [COORD_WIDTH-1:0]         pos_y,
    output logic signed [COORD_WIDTH-1:0]         vel_x,
    output logic signed [COORD_WIDTH-1:0]         vel_y,
    output logic signed [COORD_WIDTH-1:0]         acc_x,
    output logic signed [COORD_WIDTH-1:0]         acc_y,
    output logic [crse_pkg::ST_WIDTH-1:0]         status
);

    localparam int NST = crse_pkg::PIPE_STAGES;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int W   = COORD_WIDTH;
    // Wide enough for the point count, MAX_POINTS and the integer part of u.
    localparam int SW  = crse_pkg::U_WIDTH + 2;

    // ------------------------------------------------------------------
    // Configuration register. Only point_count exists; writes to any other
    // register index are dropped and read back as zero.
    // ------------------------------------------------------------------
    logic [crse_pkg::CNT_WIDTH-1:0] count_reg;
    logic                           cfg_wr;
    logic                           cfg_hit;

    assign cfg_hit = (paddr[2] == crse_pkg::REG_POINT_COUNT);
    assign cfg_wr  = psel && penable && pwrite && cfg_hit;
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? crse_pkg::PDATA_WIDTH'(count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            count_reg <= pwdata[crse_pkg::CNT_WIDTH-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it loads; the last stage is the output register.
    // ------------------------------------------------------------------
    logic [NST:1] v_reg;
    logic [NST:1] ld;
    logic         accept;
    logic         is_eval;

    always_comb
    begin
        ld[NST] = !v_reg[NST] || out_ready;
        for (int i = NST - 1; i >= 1; i--)
        begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
    end

    assign in_ready = ld[1];
    assign accept   = in_valid && ld[1];
    assign is_eval  = (opcode == crse_pkg::OP_EVAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[1])
            begin
                v_reg[1] <= in_valid && is_eval;
            end
            for (int i = 2; i <= NST; i++)
            begin
                if (ld[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: segment selection. The count is limited to MAX_POINTS; u at
    // or past the end of the curve uses the last segment with t at one, and
    // is flagged as clamped unless it lands exactly on the end.
    // ------------------------------------------------------------------
    logic [SW-1:0]          n_cnt;
    logic [SW-1:0]          segs;
    logic [SW-1:0]          whole;
    logic [SW-1:0]          seg;
    logic [FRAC_BITS-1:0]   frac;
    logic [FRAC_BITS:0]     t_sel;
    logic [crse_pkg::ST_WIDTH-1:0] st_sel;
    logic                   wr_en;

    always_comb
    begin
        n_cnt = (SW'(count_reg) > SW'(MAX_POINTS)) ? SW'(MAX_POINTS) : SW'(count_reg);
        segs  = n_cnt - SW'(3);
        whole = SW'(param_u >> FRAC_BITS);
        frac  = param_u[FRAC_BITS-1:0];
        if (n_cnt < SW'(crse_pkg::MIN_POINTS))
        begin
            seg    = '0;
            t_sel  = '0;
            st_sel = crse_pkg::ST_FEW;
        end
        else if (whole < segs)
        begin
            seg    = whole;
            t_sel  = {1'b0, frac};
            st_sel = crse_pkg::ST_OK;
        end
        else
        begin
            seg    = segs - SW'(1);
            t_sel  = {1'b1, {FRAC_BITS{1'b0}}};
            st_sel = ((whole > segs) || (frac != '0)) ? crse_pkg::ST_CLAMP : crse_pkg::ST_OK;
        end
    end

    assign wr_en = accept && (opcode == crse_pkg::OP_WRITE) && (32'(point_index) < MAX_POINTS);

    // ------------------------------------------------------------------
    // Point table: four copies, all written together, so that the four
    // consecutive points of a segment are read in the same cycle. Their read
    // registers form stage 1.
    // ------------------------------------------------------------------
    logic [2*W-1:0] tab_wdata;
    logic [2*W-1:0] tab_rdata [4];

    assign tab_wdata = {point_x, point_y};

    for (genvar g = 0; g < 4; g++)
    begin : g_tab
        crse_ram #(
            .WIDTH (2 * W),
            .DEPTH (MAX_POINTS)
        ) u_ram (
            .clk   (clk),
            .we    (wr_en),
            .waddr (AW'(point_index)),
            .wdata (tab_wdata),
            .re    (ld[1]),
            .raddr (AW'(seg + SW'(g))),
            .rdata (tab_rdata[g])
        );
    end

    // Stage-1 side data and the status that rides along with each result.
    logic [FRAC_BITS:0]            t1_reg;
    logic [crse_pkg::ST_WIDTH-1:0] st_reg [NST:1];

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            t1_reg    <= t_sel;
            st_reg[1] <= st_sel;
        end
        for (int i = 2; i <= NST; i++)
        begin
            if (ld[i])
            begin
                st_reg[i] <= st_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 to 9: one Horner pipeline per axis.
    // ------------------------------------------------------------------
    logic signed [W-1:0] ax_pos, ax_vel, ax_acc;
    logic signed [W-1:0] ay_pos, ay_vel, ay_acc;

    crse_axis #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_axis_x (
        .clk   (clk),
        .en    (ld[NST:2]),
        .p0    (tab_rdata[0][2*W-1:W]),
        .p1    (tab_rdata[1][2*W-1:W]),
        .p2    (tab_rdata[2][2*W-1:W]),
        .p3    (tab_rdata[3][2*W-1:W]),
        .t_in  (t1_reg),
        .pos   (ax_pos),
        .vel   (ax_vel),
        .acc   (ax_acc)
    );

    crse_axis #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_axis_y (
        .clk   (clk),
        .en    (ld[NST:2]),
        .p0    (tab_rdata[0][W-1:0]),
        .p1    (tab_rdata[1][W-1:0]),
        .p2    (tab_rdata[2][W-1:0]),
        .p3    (tab_rdata[3][W-1:0]),
        .t_in  (t1_reg),
        .pos   (ay_pos),
        .vel   (ay_vel),
        .acc   (ay_acc)
    );

    // With too few points the table contents are meaningless, so the
    // coordinates are forced to zero at the output.
    logic zero_out;

    assign zero_out  = (st_reg[NST] == crse_pkg::ST_FEW);
    assign out_valid = v_reg[NST];
    assign status    = st_reg[NST];
    assign pos_x     = zero_out ? '0 : ax_pos;
    assign pos_y     = zero_out ? '0 : ay_pos;
    assign vel_x     = zero_out ? '0 : ax_vel;
    assign vel_y     = zero_out ? '0 : ay_vel;
    assign acc_x     = zero_out ? '0 : ax_acc;
    assign acc_y     = zero_out ? '0 : ay_acc;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `CRSE_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !in_ready, &v_reg)
    `CRSE_ASSERT_NXT(a_eval_enters_pipe, clk, rst_n, accept && is_eval, v_reg[1])
    `CRSE_ASSERT_IMP(a_status_known, clk, rst_n, out_valid, status <= crse_pkg::ST_CLAMP)

endmodule
